// ===== hdl/acfa_pkg.sv =====
// acfa_pkg: shared types, constants and functions for the frame authenticator
// no dependencies
`timescale 1ns / 1ps
package acfa_pkg;

   localparam logic [7:0] FrameHeader = 8'd1;
   localparam logic [7:0] FrameTag    = 8'd2;
   localparam logic [7:0] FrameData   = 8'd3;

   localparam logic [1:0] KindNone   = 2'd0;
   localparam logic [1:0] KindHeader = 2'd1;
   localparam logic [1:0] KindTag    = 2'd2;
   localparam logic [1:0] KindData   = 2'd3;

   localparam logic [1:0] StageNone   = 2'd0;
   localparam logic [1:0] StageHeader = 2'd1;
   localparam logic [1:0] StageTag    = 2'd2;

   localparam logic [1:0] ReplyOk     = 2'd0;
   localparam logic [1:0] ReplyBadCrc = 2'd1;
   localparam logic [1:0] ReplySigOk  = 2'd2;
   localparam logic [1:0] ReplySigBad = 2'd3;

   localparam logic [2:0] RegKeyUpper   = 3'd0;
   localparam logic [2:0] RegKeyLower   = 3'd1;
   localparam logic [2:0] RegIvUpper    = 3'd2;
   localparam logic [2:0] RegIvLower    = 3'd3;
   localparam logic [2:0] RegNonceUpper = 3'd4;
   localparam logic [2:0] RegNonceLower = 3'd5;

   localparam logic [4:0] PosType    = 5'd0;
   localparam logic [4:0] PosLastDat = 5'd16;
   localparam logic [4:0] PosCrcHigh = 5'd17;

   // aes operand selection for the datapath
   typedef enum logic [2:0] {
      SRC_IV,
      SRC_MAC_HDR,
      SRC_CTR,
      SRC_MAC_DATA,
      SRC_CTR_ZERO
   } aes_src_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HDR_IV,
      ST_HDR_MAC,
      ST_DAT_CTR,
      ST_DAT_MAC,
      ST_DAT_MASK,
      ST_WAIT,
      ST_REPLY1,
      ST_REPLY2
   } ctrl_state_type;

   typedef struct packed {
      logic        aes_start;
      aes_src_type aes_src;
      logic        mac_load;
      logic        keep_ctr;
   } dp_cmd_type;

   typedef struct packed {
      logic aes_busy;
      logic aes_done;
      logic tag_match;
   } dp_status_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // one aes round on a 128-bit state, byte 0 in bits 127:120
   function automatic logic [127:0] aes_round(input logic [127:0] s,
                                              input logic [127:0] rk,
                                              input logic last);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
      for (int i = 0; i < 16; i++) t[i] = sbox(b[(i & 3) + 4*(((i >> 2) + (i & 3)) & 3)]);
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            x = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
      return r ^ rk;
   endfunction

   // next round key from the previous one
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
      return r;
   endfunction

endpackage

// ===== hdl/acfa_stream_if.sv =====
// acfa_stream_if: valid/ready channel carrying a generic payload
// depends on nothing
`timescale 1ns / 1ps
interface acfa_stream_if #(parameter int Width = 8);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/acfa_aes_core.sv =====
// acfa_aes_core: iterative aes-128 encryption, one round per cycle, round keys on the fly
// depends on acfa_pkg
`timescale 1ns / 1ps
module acfa_aes_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] key,
   input  logic [127:0] block_in,
   output logic         busy,
   output logic         done,
   output logic [127:0] block_out
);
   logic [127:0] state_ff, state_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   round_ff, round_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [127:0] nk;

   always_comb begin
      state_in = state_ff;
      rkey_in  = rkey_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      nk       = acfa_pkg::key_step(rkey_ff, rcon_ff);
      if (start) begin
         state_in = block_in ^ key;
         rkey_in  = key;
         rcon_in  = 8'h01;
         round_in = 4'd1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         state_in = acfa_pkg::aes_round(state_ff, nk, round_ff == 4'd10);
         rkey_in  = nk;
         rcon_in  = acfa_pkg::xtime(rcon_ff);
         round_in = round_ff + 4'd1;
         if (round_ff == 4'd10) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      rcon_ff  <= rcon_in;
      round_ff <= round_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign block_out = state_ff;
endmodule

// ===== hdl/acfa_datapath.sv =====
// acfa_datapath: key, iv, nonce, mac, tag, keystream and block registers around one aes core
// depends on acfa_pkg and acfa_aes_core
`timescale 1ns / 1ps
module acfa_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cfg_we,
   input  logic [2:0]              cfg_idx,
   input  logic [63:0]             cfg_data,
   input  logic                    byte_we,
   input  logic [3:0]              byte_idx,
   input  logic [7:0]              byte_val,
   input  logic                    tag_store,
   input  logic [15:0]             counter,
   input  acfa_pkg::dp_cmd_type    cmd,
   output acfa_pkg::dp_status_type status,
   output logic [15:0]             block_len
);
   logic [127:0] key_ff, iv_ff, nonce_ff, blk_ff, mac_ff, tag_ff, ks_ff;
   logic [127:0] aes_in, aes_out;
   logic         aes_busy, aes_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         iv_ff    <= '0;
         nonce_ff <= '0;
      end else if (cfg_we) begin
         unique case (cfg_idx)
            acfa_pkg::RegKeyUpper:   key_ff[127:64]   <= cfg_data;
            acfa_pkg::RegKeyLower:   key_ff[63:0]     <= cfg_data;
            acfa_pkg::RegIvUpper:    iv_ff[127:64]    <= cfg_data;
            acfa_pkg::RegIvLower:    iv_ff[63:0]      <= cfg_data;
            acfa_pkg::RegNonceUpper: nonce_ff[127:64] <= cfg_data;
            acfa_pkg::RegNonceLower: nonce_ff[63:0]   <= cfg_data;
            default: ;
         endcase
      end
   end

   // the final mask pass folds into the mac, other passes replace it
   always_ff @(posedge clock) begin
      if (byte_we) blk_ff[127 - 8*byte_idx -: 8] <= byte_val;
      if (tag_store) tag_ff <= blk_ff;
      if (cmd.keep_ctr) ks_ff <= aes_out;
      if (cmd.mac_load) begin
         if (cmd.aes_src == acfa_pkg::SRC_CTR_ZERO) mac_ff <= mac_ff ^ aes_out;
         else mac_ff <= aes_out;
      end
   end

   always_comb begin
      case (cmd.aes_src)
         acfa_pkg::SRC_IV:       aes_in = iv_ff;
         acfa_pkg::SRC_MAC_HDR:  aes_in = mac_ff ^ blk_ff;
         acfa_pkg::SRC_CTR:      aes_in = {nonce_ff[127:16], counter};
         acfa_pkg::SRC_MAC_DATA: aes_in = mac_ff ^ ks_ff ^ blk_ff;
         default:                aes_in = {nonce_ff[127:16], 16'h0000};
      endcase
   end

   acfa_aes_core u_aes (
      .clock(clock), .reset(reset), .start(cmd.aes_start), .key(key_ff),
      .block_in(aes_in), .busy(aes_busy), .done(aes_done), .block_out(aes_out));

   assign status.aes_busy  = aes_busy;
   assign status.aes_done  = aes_done;
   assign status.tag_match = (mac_ff ^ aes_out) == tag_ff;
   assign block_len        = blk_ff[15:0];
endmodule

// ===== hdl/acfa_controller.sv =====
// acfa_controller: frame parser, session state and aes sequencing
// depends on acfa_pkg
`timescale 1ns / 1ps
module acfa_controller #(parameter int MaxBlocks = 12287) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [7:0]              in_byte,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [1:0]              out_code,
   output logic                    out_last,
   output logic                    byte_we,
   output logic [3:0]              byte_idx,
   output logic                    tag_store,
   output logic [15:0]             counter,
   output acfa_pkg::dp_cmd_type    cmd,
   input  acfa_pkg::dp_status_type status,
   input  logic [15:0]             block_len
);
   acfa_pkg::ctrl_state_type state_ff, state_in;
   logic [4:0]  pos_ff, pos_in;
   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  stage_ff, stage_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crch_ff, crch_in;
   logic [13:0] exp_ff, exp_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [1:0]  code1_ff, code1_in, code2_ff, code2_in;
   logic        two_ff, two_in;
   logic        acc;
   logic        crc_ok;

   assign acc    = in_valid && in_ready;
   assign crc_ok = {crch_ff, in_byte} == crc_ff;

   // next state and frame bookkeeping
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      kind_in  = kind_ff;
      stage_in = stage_ff;
      crc_in   = crc_ff;
      crch_in  = crch_ff;
      exp_in   = exp_ff;
      cnt_in   = cnt_ff;
      code1_in = code1_ff;
      code2_in = code2_ff;
      two_in   = two_ff;
      unique case (state_ff)
         acfa_pkg::ST_IDLE: begin
            if (acc) begin
               if (pos_ff == acfa_pkg::PosType) begin
                  case (in_byte)
                     acfa_pkg::FrameHeader: begin
                        stage_in = acfa_pkg::StageNone;
                        kind_in = acfa_pkg::KindHeader;
                        pos_in = 5'd1; crc_in = '0;
                     end
                     acfa_pkg::FrameTag: begin
                        if (stage_ff == acfa_pkg::StageHeader) begin
                           kind_in = acfa_pkg::KindTag; pos_in = 5'd1; crc_in = '0;
                        end else stage_in = acfa_pkg::StageNone;
                     end
                     acfa_pkg::FrameData: begin
                        if (stage_ff == acfa_pkg::StageTag) begin
                           kind_in = acfa_pkg::KindData; pos_in = 5'd1; crc_in = '0;
                        end else stage_in = acfa_pkg::StageNone;
                     end
                     default: begin
                        cnt_in = '0; exp_in = '0; stage_in = acfa_pkg::StageNone;
                     end
                  endcase
               end else if (pos_ff <= acfa_pkg::PosLastDat) begin
                  crc_in = acfa_pkg::crc_byte(crc_ff, in_byte);
                  pos_in = pos_ff + 5'd1;
               end else if (pos_ff == acfa_pkg::PosCrcHigh) begin
                  crch_in = in_byte;
                  pos_in = pos_ff + 5'd1;
               end else begin
                  pos_in = acfa_pkg::PosType;
                  two_in = 1'b0;
                  code1_in = acfa_pkg::ReplyOk;
                  state_in = acfa_pkg::ST_REPLY1;
                  if (!crc_ok) begin
                     code1_in = acfa_pkg::ReplyBadCrc;
                     if (kind_ff == acfa_pkg::KindTag) stage_in = acfa_pkg::StageNone;
                  end else begin
                     case (kind_ff)
                        acfa_pkg::KindHeader: begin
                           if (block_len > 16'(MaxBlocks)) exp_in = '0;
                           else begin
                              exp_in = block_len[13:0];
                              stage_in = acfa_pkg::StageHeader;
                              state_in = acfa_pkg::ST_HDR_IV;
                           end
                        end
                        acfa_pkg::KindTag: begin
                           stage_in = acfa_pkg::StageTag;
                           cnt_in = '0;
                        end
                        default: begin
                           cnt_in = cnt_ff + 16'd1;
                           state_in = acfa_pkg::ST_DAT_CTR;
                        end
                     endcase
                  end
               end
            end
         end
         acfa_pkg::ST_HDR_IV:
            if (status.aes_done) state_in = acfa_pkg::ST_HDR_MAC;
         acfa_pkg::ST_HDR_MAC:
            if (status.aes_done) state_in = acfa_pkg::ST_REPLY1;
         acfa_pkg::ST_DAT_CTR:
            if (status.aes_done) state_in = acfa_pkg::ST_DAT_MAC;
         acfa_pkg::ST_DAT_MAC:
            if (status.aes_done) begin
               if (cnt_ff == {2'b00, exp_ff}) state_in = acfa_pkg::ST_DAT_MASK;
               else state_in = acfa_pkg::ST_REPLY1;
            end
         acfa_pkg::ST_DAT_MASK:
            if (status.aes_done) begin
               two_in = 1'b1;
               code2_in = status.tag_match ? acfa_pkg::ReplySigOk : acfa_pkg::ReplySigBad;
               state_in = acfa_pkg::ST_REPLY1;
            end
         acfa_pkg::ST_REPLY1:
            if (out_ready) state_in = two_ff ? acfa_pkg::ST_REPLY2 : acfa_pkg::ST_IDLE;
         acfa_pkg::ST_REPLY2:
            if (out_ready) state_in = acfa_pkg::ST_IDLE;
         default: state_in = acfa_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath commands; start is issued once, busy and done hold it off
   always_comb begin
      in_ready      = 1'b0;
      out_valid     = 1'b0;
      out_code      = code1_ff;
      out_last      = 1'b0;
      cmd.aes_start = 1'b0;
      cmd.aes_src   = acfa_pkg::SRC_IV;
      cmd.mac_load  = 1'b0;
      cmd.keep_ctr  = 1'b0;
      unique case (state_ff)
         acfa_pkg::ST_IDLE: in_ready = 1'b1;
         acfa_pkg::ST_HDR_IV: begin
            cmd.aes_src = acfa_pkg::SRC_IV;
            cmd.aes_start = !status.aes_busy && !status.aes_done;
            cmd.mac_load = status.aes_done;
         end
         acfa_pkg::ST_HDR_MAC: begin
            cmd.aes_src = acfa_pkg::SRC_MAC_HDR;
            cmd.aes_start = !status.aes_busy && !status.aes_done;
            cmd.mac_load = status.aes_done;
         end
         acfa_pkg::ST_DAT_CTR: begin
            cmd.aes_src = acfa_pkg::SRC_CTR;
            cmd.aes_start = !status.aes_busy && !status.aes_done;
            cmd.keep_ctr = status.aes_done;
         end
         acfa_pkg::ST_DAT_MAC: begin
            cmd.aes_src = acfa_pkg::SRC_MAC_DATA;
            cmd.aes_start = !status.aes_busy && !status.aes_done;
            cmd.mac_load = status.aes_done;
         end
         acfa_pkg::ST_DAT_MASK: begin
            cmd.aes_src = acfa_pkg::SRC_CTR_ZERO;
            cmd.aes_start = !status.aes_busy && !status.aes_done;
            cmd.mac_load = status.aes_done;
         end
         acfa_pkg::ST_REPLY1: begin
            out_valid = 1'b1;
            out_last = !two_ff;
         end
         acfa_pkg::ST_REPLY2: begin
            out_valid = 1'b1;
            out_code = code2_ff;
            out_last = 1'b1;
         end
         default: ;
      endcase
   end

   assign byte_we   = acc && state_ff == acfa_pkg::ST_IDLE && pos_ff != acfa_pkg::PosType
                      && pos_ff <= acfa_pkg::PosLastDat;
   assign byte_idx  = 4'(pos_ff - 5'd1);
   assign tag_store = acc && pos_ff > acfa_pkg::PosCrcHigh && kind_ff == acfa_pkg::KindTag;
   assign counter   = cnt_ff;

   always_ff @(posedge clock) begin
      crch_ff  <= crch_in;
      code1_ff <= code1_in;
      code2_ff <= code2_in;
      two_ff   <= two_in;
      if (reset) begin
         state_ff <= acfa_pkg::ST_IDLE;
         pos_ff   <= '0;
         kind_ff  <= '0;
         stage_ff <= '0;
         crc_ff   <= '0;
         exp_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         kind_ff  <= kind_in;
         stage_ff <= stage_in;
         crc_ff   <= crc_in;
         exp_ff   <= exp_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule

// ===== hdl/aes_ccm_frame_authenticator.sv =====
// replies: a byte that ends a frame with no aes work is taken and its reply offered the next
// cycle; a header frame costs two aes passes and a data frame two or three, each pass run in
// the shared aes core (start, ten rounds, done)
// throughput: one byte per cycle within a frame; the next byte waits until all replies are taken
// reset: synchronous, active high; clears configuration registers, session and frame position
`timescale 1ns / 1ps
module aes_ccm_frame_authenticator #(parameter int MAX_BLOCKS = 12287) (
   input  logic                clock,
   input  logic                reset,
   acfa_stream_if.sink         req,
   acfa_stream_if.source       rsp,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_wdata
);
   acfa_pkg::dp_cmd_type    cmd;
   acfa_pkg::dp_status_type status;
   logic        byte_we, tag_store;
   logic [3:0]  byte_idx;
   logic [15:0] counter, block_len;
   logic [1:0]  code;
   logic        last;

   // controller: parses the byte stream and sequences the aes passes
   acfa_controller #(.MaxBlocks(MAX_BLOCKS)) u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_byte(req.payload),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_code(code), .out_last(last),
      .byte_we(byte_we), .byte_idx(byte_idx), .tag_store(tag_store), .counter(counter),
      .cmd(cmd), .status(status), .block_len(block_len));

   // datapath: configuration, block buffer, mac and tag around the aes core
   acfa_datapath u_dp (
      .clock(clock), .reset(reset),
      .cfg_we(csr_we), .cfg_idx(csr_index), .cfg_data(csr_wdata),
      .byte_we(byte_we), .byte_idx(byte_idx), .byte_val(req.payload),
      .tag_store(tag_store), .counter(counter), .cmd(cmd), .status(status),
      .block_len(block_len));

   // payload bit 2 is the last-of-run flag, bits 1:0 the reply code
   assign rsp.payload = {last, code};
endmodule
